[sv/wdef_pkg.sv]
// Shared types, codes and helper functions of the wide deblocking edge filter.
`default_nettype none
package wdef_pkg;

  // One line across the edge: element 0 is p7, 7 is p0, 8 is q0, 15 is q7.
  typedef logic [15:0][7:0] line_t;

  // Per-line filter decisions.
  typedef struct packed {
    logic mask;
    logic hev;
    logic flat;
    logic flat2;
  } decision_t;

  typedef struct packed {
    logic [7:0] limit;
    logic [7:0] blimit;
    logic [7:0] hev_threshold;
  } cfg_t;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEV    = 2'd2;

  localparam logic [1:0] PATH_OFF     = 2'd0;
  localparam logic [1:0] PATH_FOUR    = 2'd1;
  localparam logic [1:0] PATH_SEVEN   = 2'd2;
  localparam logic [1:0] PATH_FIFTEEN = 2'd3;

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Saturate a 10-bit signed value to the signed 8-bit range.
  function automatic logic signed [7:0] sat8(input logic signed [9:0] v);
    logic signed [7:0] r;
    if (v < -10'sd128) begin
      r = -8'sd128;
    end else if (v > 10'sd127) begin
      r = 8'sd127;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  function automatic logic signed [9:0] sx10(input logic signed [7:0] v);
    return {{2{v[7]}}, v};
  endfunction

endpackage
`default_nettype wire

[sv/wdef_decide.sv]
// Edge mask, high edge variance and flatness decisions for one line.
`default_nettype none
module wdef_decide
  import wdef_pkg::*;
(
  input  line_t     x_i,
  input  cfg_t      cfg_i,
  output decision_t dec_o
);

  logic [7:0] inner;
  logic [7:0] mx;
  logic [7:0] outer_diff;
  logic [9:0] edge_sum;
  logic       flat_near;
  logic       flat_far;

  always_comb begin
    inner = absdiff(x_i[6], x_i[7]);
    if (absdiff(x_i[9], x_i[8]) > inner) begin
      inner = absdiff(x_i[9], x_i[8]);
    end
    mx = inner;
    if (absdiff(x_i[4], x_i[5]) > mx) mx = absdiff(x_i[4], x_i[5]);
    if (absdiff(x_i[5], x_i[6]) > mx) mx = absdiff(x_i[5], x_i[6]);
    if (absdiff(x_i[10], x_i[9]) > mx) mx = absdiff(x_i[10], x_i[9]);
    if (absdiff(x_i[11], x_i[10]) > mx) mx = absdiff(x_i[11], x_i[10]);

    // The edge step is kept at full width, with no saturation.
    outer_diff = absdiff(x_i[6], x_i[9]);
    edge_sum = {1'b0, absdiff(x_i[7], x_i[8]), 1'b0}
             + {3'b000, outer_diff[7:1]};

    flat_near = 1'b1;
    for (int i = 4; i <= 6; i++) begin
      if (absdiff(x_i[i], x_i[7]) > 8'd1) flat_near = 1'b0;
    end
    for (int i = 9; i <= 11; i++) begin
      if (absdiff(x_i[i], x_i[8]) > 8'd1) flat_near = 1'b0;
    end

    flat_far = 1'b1;
    for (int i = 0; i <= 3; i++) begin
      if (absdiff(x_i[i], x_i[7]) > 8'd1) flat_far = 1'b0;
    end
    for (int i = 12; i <= 15; i++) begin
      if (absdiff(x_i[i], x_i[8]) > 8'd1) flat_far = 1'b0;
    end

    dec_o.hev   = inner > cfg_i.hev_threshold;
    dec_o.mask  = (mx <= cfg_i.limit) && (edge_sum <= {2'b00, cfg_i.blimit});
    dec_o.flat  = dec_o.mask && flat_near;
    dec_o.flat2 = dec_o.flat && flat_far;
  end

endmodule
`default_nettype wire

[sv/wdef_filter.sv]
// Fifteen-tap, seven-tap and four-tap filters with the path selection.
`default_nettype none
module wdef_filter
  import wdef_pkg::*;
(
  input  line_t      x_i,
  input  decision_t  dec_i,
  output line_t      y_o,
  output logic [1:0] path_o
);

  line_t y15;
  line_t y7;
  line_t y4;

  // Rounded averages; window indices are clamped to the ends of the window
  // and the center pixel counts twice.
  always_comb begin
    logic [11:0] s15;
    logic [10:0] s7;
    int          j;
    y15 = x_i;
    for (int c = 1; c <= 14; c++) begin
      s15 = {4'd0, x_i[c]} + 12'd8;
      for (int k = -7; k <= 7; k++) begin
        j = c + k;
        if (j < 0) j = 0;
        if (j > 15) j = 15;
        s15 = s15 + {4'd0, x_i[j]};
      end
      y15[c] = s15[11:4];
    end
    y7 = x_i;
    for (int c = 5; c <= 10; c++) begin
      s7 = {3'd0, x_i[c]} + 11'd4;
      for (int k = -3; k <= 3; k++) begin
        j = c + k;
        if (j < 4) j = 4;
        if (j > 11) j = 11;
        s7 = s7 + {3'd0, x_i[j]};
      end
      y7[c] = s7[10:3];
    end
  end

  // Signed four-tap filter on pixels offset by 128.
  always_comb begin
    logic signed [7:0] ps1, ps0, qs0, qs1;
    logic signed [7:0] f, t, f1, f2, fo;
    logic signed [9:0] f1p;
    ps1 = {~x_i[6][7], x_i[6][6:0]};
    ps0 = {~x_i[7][7], x_i[7][6:0]};
    qs0 = {~x_i[8][7], x_i[8][6:0]};
    qs1 = {~x_i[9][7], x_i[9][6:0]};
    f   = dec_i.hev ? sat8(sx10(ps1) - sx10(qs1)) : 8'sd0;
    t   = sat8(sx10(qs0) - sx10(ps0));
    f   = sat8(sx10(f) + sx10(t));
    f   = sat8(sx10(f) + sx10(t));
    f   = sat8(sx10(f) + sx10(t));
    f1  = sat8(sx10(f) + 10'sd4) >>> 3;
    f2  = sat8(sx10(f) + 10'sd3) >>> 3;
    f1p = (sx10(f1) + 10'sd1) >>> 1;
    fo  = dec_i.hev ? 8'sd0 : f1p[7:0];
    y4    = x_i;
    y4[8] = sat8(sx10(qs0) - sx10(f1)) ^ 8'h80;
    y4[7] = sat8(sx10(ps0) + sx10(f2)) ^ 8'h80;
    y4[9] = sat8(sx10(qs1) - sx10(fo)) ^ 8'h80;
    y4[6] = sat8(sx10(ps1) + sx10(fo)) ^ 8'h80;
  end

  always_comb begin
    if (dec_i.flat2) begin
      y_o    = y15;
      path_o = PATH_FIFTEEN;
    end else if (dec_i.flat) begin
      y_o    = y7;
      path_o = PATH_SEVEN;
    end else if (dec_i.mask) begin
      y_o    = y4;
      path_o = PATH_FOUR;
    end else begin
      y_o    = x_i;
      path_o = PATH_OFF;
    end
  end

endmodule
`default_nettype wire

[sv/wide_deblocking_edge_filter_top.sv]
// Top level of the wide deblocking edge filter: registers, handshakes and datapath.
`default_nettype none
// One pixel line across a block edge enters per transaction and one filtered
// line leaves per transaction. The block takes a new line every clock cycle
// unless out_ready_i holds back a pending result; each line passes through
// the input register and then the result register, with the mask decision
// and all three filters computed in a single combinational pass between
// them. Configuration writes (limit, blimit, hev_threshold) are accepted in
// every cycle and should only be made while no line is in flight. Writes to
// an index beyond the three registers are ignored.
module wide_deblocking_edge_filter_top
  import wdef_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [7:0]           cfg_data_i,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire logic [63:0]          p_pixels_i,
  input  wire logic [63:0]          q_pixels_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  output      logic [55:0]          p_filtered_o,
  output      logic [55:0]          q_filtered_o,
  output      logic [1:0]           filter_path_o
);

  cfg_t       cfg_q;
  logic       in_valid_q;
  line_t      line_q;
  line_t      line_d;
  logic       out_valid_q;
  logic [55:0] p_out_q, q_out_q;
  logic [1:0] path_q;

  decision_t  dec;
  line_t      y;
  logic [1:0] path;
  logic [55:0] p_out_d, q_out_d;
  logic       out_load;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LIMIT:  cfg_q.limit         <= cfg_data_i;
        CFG_BLIMIT: cfg_q.blimit        <= cfg_data_i;
        CFG_HEV:    cfg_q.hev_threshold <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The result register frees when its transaction completes, so the input
  // stage can move on in the same cycle.
  assign out_load   = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || out_load;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      line_d[7 - i] = p_pixels_i[8*i +: 8];
      line_d[8 + i] = q_pixels_i[8*i +: 8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      line_q <= line_d;
    end
  end

  wdef_decide u_decide (
    .x_i   (line_q),
    .cfg_i (cfg_q),
    .dec_o (dec)
  );

  wdef_filter u_filter (
    .x_i    (line_q),
    .dec_i  (dec),
    .y_o    (y),
    .path_o (path)
  );

  always_comb begin
    for (int i = 0; i < 7; i++) begin
      p_out_d[8*i +: 8] = y[7 - i];
      q_out_d[8*i +: 8] = y[8 + i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && in_valid_q) begin
      p_out_q <= p_out_d;
      q_out_q <= q_out_d;
      path_q  <= path;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign p_filtered_o  = p_out_q;
  assign q_filtered_o  = q_out_q;
  assign filter_path_o = path_q;

endmodule
`default_nettype wire
